[hdl/edv_pkg.sv]
`timescale 1ns / 1ps

package edv_pkg;

  localparam int DividendBits = 36;
  localparam int DivisorBits  = 32;
  localparam int DivSteps     = DividendBits;
  localparam int StepCntBits  = $clog2(DivSteps + 1);
  localparam int DeltaBits    = 18;
  localparam int MagBits      = 17;
  localparam int TotalBits    = 32;
  localparam int VelBits      = 40;
  localparam int CfgIdxBits   = 2;

  localparam logic [19:0] UsecPerSec = 20'd1000000;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_AUTORELOAD = 2'd0,
    CFG_REVERSE    = 2'd1
  } cfg_index_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_START,
    S_DIV,
    S_DONE
  } edv_state_e;

  typedef struct packed {
    logic                    start;
    logic [DividendBits-1:0] dividend;
    logic [DivisorBits-1:0]  divisor;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[hdl/encoder_delta_velocity_unit.sv]
`timescale 1ns / 1ps

// Encoder delta/velocity unit. Each input word is one sample of an up/down encoder
// timer (count, counting-down flag, microseconds since the last sample). The unit
// resolves counter wraps with period autoreload+1, applies the reverse setting,
// keeps a wrapping 32-bit tick total and reports velocity in ticks per second as
// delta*1000000/elapsed truncated toward zero (elapsed 0 counts as 1). One sample
// is in flight at a time and passes through the multiply step, the 36-step
// bit-serial divider and the load step into the output register. A new
// sample is taken as soon as the previous one has reached the output register,
// even if that result has not been taken yet. Write configuration only when idle.
module encoder_delta_velocity_unit #(
  parameter int COUNTER_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // sample input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // counter_value[15:0], counting_down[16],
                                     // elapsed_us[48:17], zero[55:49]
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata   // tick_delta[17:0], tick_total[49:18],
                                     // velocity[89:50], zero[95:90]
);
  import edv_pkg::*;

  edv_state_e state_q, state_d;

  logic                        accept, cfg_we;
  logic                        mul_en, div_start, out_load;
  logic signed [DeltaBits-1:0] delta;
  logic signed [TotalBits-1:0] total;
  logic [DivisorBits-1:0]      elapsed_q;
  logic [DividendBits-1:0]     product_q;
  logic [MagBits-1:0]          mag;
  logic [36:0]                 product_full;
  logic                        neg;
  div_cmd_t                    div_cmd;
  div_stat_t                   div_stat;
  logic [DividendBits-1:0]     quotient;
  logic [VelBits-1:0]          vel;

  logic                        out_valid_q;
  logic [DeltaBits-1:0]        out_delta_q;
  logic [TotalBits-1:0]        out_total_q;
  logic [VelBits-1:0]          out_vel_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign accept      = s_axis_tvalid & s_axis_tready;

  edv_tick_unit #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_tick (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .sample_we_i    (accept),
    .counter_value_i(s_axis_tdata[15:0]),
    .counting_down_i(s_axis_tdata[16]),
    .delta_o        (delta),
    .total_o        (total)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_MUL;
      S_MUL:   state_d = S_START;
      S_START: state_d = S_DIV;
      S_DIV:   if (div_stat.done) state_d = S_DONE;
      S_DONE:  if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    mul_en        = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      S_IDLE:  s_axis_tready = 1'b1;
      S_MUL:   mul_en        = 1'b1;
      S_START: div_start     = 1'b1;
      S_DONE:  out_load      = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_comb begin
    neg          = delta[DeltaBits-1];
    mag          = neg ? MagBits'(-delta) : MagBits'(delta);
    product_full = mag * UsecPerSec;
    div_cmd.start    = div_start;
    div_cmd.dividend = product_q;
    div_cmd.divisor  = elapsed_q;
    vel = neg ? -{{(VelBits-DividendBits){1'b0}}, quotient}
              :  {{(VelBits-DividendBits){1'b0}}, quotient};
  end

  edv_serial_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (div_cmd),
    .stat_o    (div_stat),
    .quotient_o(quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      elapsed_q <= (s_axis_tdata[48:17] == '0) ? 32'd1 : s_axis_tdata[48:17];
    end
    if (mul_en) begin
      // |delta| * 1e6 stays below 2^36
      product_q <= product_full[DividendBits-1:0];
    end
    if (out_load) begin
      out_delta_q <= delta;
      out_total_q <= total;
      out_vel_q   <= vel;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_vel_q, out_total_q, out_delta_q};

`ifndef SYNTHESIS
  a_accept_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !div_stat.busy)
    else $error("sample taken while divider busy");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIV))
    else $error("divider finished outside divide state");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !m_axis_tready) |=> (state_q == S_DONE))
    else $error("result loaded over an untaken word");
`endif

endmodule

[hdl/edv_tick_unit.sv]
`timescale 1ns / 1ps

module edv_tick_unit #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [edv_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [15:0]                     cfg_data_i,
  input  logic                            sample_we_i,
  input  logic [15:0]                     counter_value_i,
  input  logic                            counting_down_i,
  output logic signed [edv_pkg::DeltaBits-1:0] delta_o,
  output logic signed [edv_pkg::TotalBits-1:0] total_o
);
  import edv_pkg::*;

  localparam int KeepBits = (COUNTER_BITS < 16) ? COUNTER_BITS : 16;
  localparam logic [15:0] CountMask = 16'hFFFF >> (16 - KeepBits);

  logic [15:0]                 autoreload_q;
  logic                        reverse_q;
  logic [15:0]                 prev_q;
  logic signed [TotalBits-1:0] total_q, total_d;
  logic [15:0]                 now;
  logic signed [DeltaBits-1:0] diff, period, delta_raw, delta_d;

  always_comb begin
    now       = counter_value_i & CountMask;
    diff      = $signed({2'b00, now}) - $signed({2'b00, prev_q});
    period    = $signed({2'b00, autoreload_q}) + 18'sd1;
    delta_raw = '0;
    if (now > prev_q) begin
      delta_raw = counting_down_i ? (diff - period) : diff;
    end else if (now < prev_q) begin
      delta_raw = counting_down_i ? diff : (diff + period);
    end
    delta_d = reverse_q ? -delta_raw : delta_raw;
    total_d = total_q + TotalBits'(delta_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      autoreload_q <= 16'hFFFF;
      reverse_q    <= 1'b0;
      prev_q       <= '0;
      total_q      <= '0;
      delta_o      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_AUTORELOAD: autoreload_q <= cfg_data_i;
          CFG_REVERSE:    reverse_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (sample_we_i) begin
        prev_q  <= now;
        total_q <= total_d;
        delta_o <= delta_d;
      end
    end
  end

  assign total_o = total_q;

endmodule

[hdl/edv_serial_div.sv]
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module edv_serial_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  edv_pkg::div_cmd_t                 cmd_i,
  output edv_pkg::div_stat_t                stat_o,
  output logic [edv_pkg::DividendBits-1:0]  quotient_o
);
  import edv_pkg::*;

  logic [StepCntBits-1:0]  cnt_q;
  logic                    done_q;
  logic [DivisorBits-1:0]  rem_q;
  logic [DivisorBits-1:0]  dsr_q;
  logic [DividendBits-1:0] quo_q;
  logic [DivisorBits:0]    trial, trial_sub;
  logic                    ge;

  always_comb begin
    trial     = {rem_q, quo_q[DividendBits-1]};
    trial_sub = trial - {1'b0, dsr_q};
    ge        = trial >= {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        cnt_q <= StepCntBits'(DivSteps);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == StepCntBits'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rem_q <= '0;
      dsr_q <= cmd_i.divisor;
      quo_q <= cmd_i.dividend;
    end else if (cnt_q != '0) begin
      // remainder stays below the divisor, so the top trial bit drops out
      rem_q <= ge ? trial_sub[DivisorBits-1:0] : trial[DivisorBits-1:0];
      quo_q <= {quo_q[DividendBits-2:0], ge};
    end
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

[test/tb_encoder_delta_velocity_unit.sv]
`timescale 1ns / 1ps

module tb_encoder_delta_velocity_unit;
  import edv_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int RandomPerPhase = 125;
  localparam int NumPhases = 8;

  typedef struct packed {
    logic [31:0] elapsed;
    logic        down;
    logic [15:0] count;
  } sample_t;

  typedef struct packed {
    logic [39:0] velocity;
    logic [31:0] total;
    logic [17:0] delta;
  } motion_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_AUTORELOAD;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;

  encoder_delta_velocity_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state, mirrors the block after reset
  logic [15:0] top_value = 16'hFFFF;
  logic        mirror = 1'b0;
  logic [15:0] last_count = '0;
  logic [31:0] tick_sum = '0;

  sample_t pending_q[$];
  motion_t motion_q[$];
  int      fail_count = 0;
  int      cycle_count = 0;

  // position of the simulated encoder, used to build plausible sample streams
  int enc_pos = 0;

  function automatic motion_t predict_motion(sample_t s);
    motion_t            r;
    longint             period;
    longint             dlt;
    longint unsigned    mag;
    longint unsigned    el;
    longint unsigned    q;
    longint             vel;
    period = longint'(top_value) + 1;
    dlt = 0;
    if (s.count > last_count) begin
      dlt = s.down ? (longint'(s.count) - longint'(last_count) - period)
                   : (longint'(s.count) - longint'(last_count));
    end else if (s.count < last_count) begin
      dlt = s.down ? (longint'(s.count) - longint'(last_count))
                   : (longint'(s.count) - longint'(last_count) + period);
    end
    if (mirror) dlt = -dlt;
    tick_sum = tick_sum + dlt[31:0];
    last_count = s.count;
    el = (s.elapsed == 32'd0) ? 64'd1 : {32'd0, s.elapsed};
    mag = (dlt < 0) ? longint'(-dlt) : longint'(dlt);
    q = (mag * 64'd1000000) / el;
    vel = (dlt < 0) ? -longint'(q) : longint'(q);
    r.delta = dlt[17:0];
    r.total = tick_sum;
    r.velocity = vel[39:0];
    return r;
  endfunction

  // sample driver: bursts of words with random gaps in between
  sample_t cur_sample;
  int      burst_left = 0;
  int      gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        motion_q.push_back(predict_motion(cur_sample));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 6);
          end
          cur_sample = pending_q.pop_front();
          s_axis_tdata <= {7'd0, cur_sample.elapsed, cur_sample.down, cur_sample.count};
          s_axis_tvalid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 50);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result backpressure, switching between free flow, choppy and long stalls
  int stall_mode = 0;
  int mode_left = 0;
  int stall_left = 0;

  always @(posedge clk_i) begin
    logic ready_next;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(50, 400);
    end else begin
      mode_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      ready_next = 1'b0;
    end else begin
      ready_next = 1'b1;
      if (stall_mode == 1 && $urandom_range(0, 1) == 0) begin
        stall_left = $urandom_range(0, 2);
        ready_next = 1'b0;
      end else if (stall_mode == 2 && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 39);
        ready_next = 1'b0;
      end
    end
    m_axis_tready <= ready_next;
  end

  // result monitor
  always @(posedge clk_i) begin
    motion_t exp_m;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (motion_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $realtime, m_axis_tdata);
        fail_count++;
      end else begin
        exp_m = motion_q.pop_front();
        if (m_axis_tdata[17:0] !== exp_m.delta) begin
          $display("%0t: tick_delta expected %h got %h", $realtime, exp_m.delta,
                   m_axis_tdata[17:0]);
          fail_count++;
        end
        if (m_axis_tdata[49:18] !== exp_m.total) begin
          $display("%0t: tick_total expected %h got %h", $realtime, exp_m.total,
                   m_axis_tdata[49:18]);
          fail_count++;
        end
        if (m_axis_tdata[89:50] !== exp_m.velocity) begin
          $display("%0t: velocity expected %h got %h", $realtime, exp_m.velocity,
                   m_axis_tdata[89:50]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic add_sample(logic [15:0] count, logic down, logic [31:0] elapsed);
    sample_t s;
    s.count = count;
    s.down = down;
    s.elapsed = elapsed;
    pending_q.push_back(s);
  endtask

  function automatic logic [31:0] pick_elapsed();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return $urandom_range(1, 10);
      2:       return $urandom();
      3:       return $urandom_range(100, 20000);
      default: return $urandom_range(500, 5000);
    endcase
  endfunction

  // mostly a moving encoder with consistent direction flags, some raw noise
  task automatic add_random_samples(int n, int top);
    int period;
    int step;
    int span;
    int cnt;
    logic dn;
    period = top + 1;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        cnt = $urandom_range(0, 65535);
        dn = $urandom_range(0, 1);
      end else begin
        case ($urandom_range(0, 2))
          0:       span = 4;
          1:       span = 100;
          default: span = top / 2;
        endcase
        step = $urandom_range(0, span);
        if ($urandom_range(0, 1) == 0) step = -step;
        cnt = ((enc_pos + step) % period + period) % period;
        dn = (step < 0) ? 1'b1 : (step > 0) ? 1'b0 : logic'($urandom_range(0, 1));
      end
      enc_pos = cnt % period;
      add_sample(cnt[15:0], dn, pick_elapsed());
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || s_axis_tvalid || motion_q.size() != 0);
  endtask

  task automatic write_setting(cfg_index_e idx, logic [15:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_AUTORELOAD: top_value = value;
      CFG_REVERSE:    mirror = value[0];
      default:        ;
    endcase
  endtask

  int phase_top[NumPhases] = '{65535, 65535, 1, 999, 2, 40000, 0, 65535};
  int phase_rev[NumPhases] = '{0, 1, 0, 1, 1, 0, 0, 0};

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: equal counts, zero and max elapsed, both wrap directions
    add_sample(16'd0, 1'b0, 32'd0);
    add_sample(16'd100, 1'b0, 32'd1000);
    add_sample(16'd100, 1'b1, 32'hFFFF_FFFF);
    add_sample(16'd50, 1'b1, 32'd1);
    add_sample(16'd65535, 1'b1, 32'd0);
    add_sample(16'd10, 1'b0, 32'd7);
    add_sample(16'd65535, 1'b0, 32'd1);
    add_sample(16'd0, 1'b1, 32'd1);
    add_sample(16'd65535, 1'b1, 32'h8000_0000);
    add_sample(16'd65534, 1'b0, 32'd3);
    add_sample(16'd1, 1'b1, 32'hFFFF_FFFF);
    add_sample(16'h5555, 1'b0, 32'h5555_5555);
    add_sample(16'hAAAA, 1'b1, 32'hAAAA_AAAA);
    add_sample(16'hAAAA, 1'b0, 32'd0);
    enc_pos = 16'hAAAA;
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      if (phase_top[p] == 0) phase_top[p] = $urandom_range(1, 65535);
      if (p == 6) phase_rev[p] = $urandom_range(0, 1);
      write_setting(CFG_AUTORELOAD, phase_top[p][15:0]);
      write_setting(CFG_REVERSE, phase_rev[p][15:0]);
      @(negedge clk_i);
      enc_pos = enc_pos % (phase_top[p] + 1);
      // counter beyond the top value right after a setting change
      if (phase_top[p] < 65535) add_sample(16'hFFFF, 1'b0, pick_elapsed());
      add_random_samples(RandomPerPhase, phase_top[p]);
      wait_idle();
    end

    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && motion_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
